>>> rtl/vam_pkg.sv
// Shared types and constants of the four-voice allocate-and-mix block.
`default_nettype none

package vam_pkg;

    localparam int VOICES_DEF     = 4;
    localparam int ADDR_BITS_DEF  = 24;
    localparam int IDX_W          = 4;
    localparam int SAMPLE_W       = 16;
    localparam int LEN_W          = 24;
    localparam int ID_W           = 8;
    localparam int OUT_ADDR_W     = 24;
    localparam int PORT_VOICES    = 4;
    localparam int IN_DATA_W      = 120;
    localparam int OUT_DATA_W     = 120;

    localparam int BIAS_U8        = 128;
    localparam int MAX_U8         = 255;
    localparam int MAX_S16        = 32767;
    localparam int MIN_S16        = -32768;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_MIX     = 1'b1;

    localparam logic CFG_SOURCE_16 = 1'b0;
    localparam logic CFG_DEVICE_16 = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } vam_cmd_t;

    typedef struct packed {
        logic out_free;
    } vam_status_t;

endpackage

`default_nettype wire

>>> rtl/voice_allocate_and_mix_core.sv
// Top level of the four-voice allocate-and-mix block with voice stealing and clipping.
`default_nettype none

// Channel   Handshake           Contents
// s_*       s_tvalid/s_tready   tuser: func; tdata: sound_id, sound_base, sound_len,
//                               voice0_sample .. voice3_sample
// m_*       m_tvalid/m_tready   tdata: accepted, chosen_voice, mixed_sample,
//                               active_mask, voice0_addr .. voice3_addr
// cfg_*     cfg_we              index 0 source_is_16bit, index 1 device_is_16bit
//
// Each transaction is captured, then stepped voice by voice through the shared accumulator
// and compare unit, then the allocation is committed and the result register loaded.
// Reset clears all voices, the configuration and the control and valid flags, not the data registers.
// A result waits in its register while the next transaction is taken in; the block
// stalls before committing only while that register is still full.

module voice_allocate_and_mix_core #(
    parameter int VOICES    = vam_pkg::VOICES_DEF,
    parameter int ADDR_BITS = vam_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic                           cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sound_id[7:0], sound_base[31:8], sound_len[55:32], voice0_sample[71:56],
    // voice1_sample[87:72], voice2_sample[103:88], voice3_sample[119:104]
    input  logic [vam_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[0]
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // accepted[0], chosen_voice[2:1], mixed_sample[18:3], active_mask[22:19],
    // voice0_addr[46:23], voice1_addr[70:47], voice2_addr[94:71],
    // voice3_addr[118:95], zero[119]
    output logic [vam_pkg::OUT_DATA_W-1:0] m_tdata
);
    import vam_pkg::*;

    vam_cmd_t    cmd;
    vam_status_t status;

    vam_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vam_datapath #(
        .VOICES    (VOICES),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

>>> rtl/vam_ctrl.sv
// Controller state machine that sequences capture, per-voice steps and result write.
`default_nettype none

module vam_ctrl #(
    parameter int VOICES = vam_pkg::VOICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  vam_pkg::vam_status_t status,
    output vam_pkg::vam_cmd_t    cmd
);
    import vam_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/vam_datapath.sv
// Datapath: voice state, shared accumulator and compare unit, clipping and result register.
`default_nettype none

module vam_datapath #(
    parameter int VOICES    = vam_pkg::VOICES_DEF,
    parameter int ADDR_BITS = vam_pkg::ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic                              cfg_wdata,
    input  logic [vam_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vam_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  vam_pkg::vam_cmd_t                 cmd,
    output vam_pkg::vam_status_t              status
);
    import vam_pkg::*;

    localparam int VIW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW     = (ADDR_BITS < OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;
    localparam int ACC_W  = SAMPLE_W + 1 + VIW;
    localparam int WIDE_W = ACC_W + 9;

    // Configuration registers.
    logic source_is_16bit_reg;
    logic device_is_16bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_is_16bit_reg <= 1'b0;
            device_is_16bit_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SOURCE_16)
            begin
                source_is_16bit_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_DEVICE_16)
            begin
                device_is_16bit_reg <= cfg_wdata;
            end
        end
    end

    // Captured transaction.
    logic                       func_reg;
    logic [ID_W-1:0]            id_reg;
    logic [AW-1:0]              base_reg;
    logic [LEN_W-1:0]           len_reg;
    logic signed [SAMPLE_W-1:0] smp_reg [0:PORT_VOICES-1];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= s_tuser[0];
            id_reg     <= s_tdata[7:0];
            base_reg   <= s_tdata[8 +: AW];
            len_reg    <= s_tdata[55:32];
            smp_reg[0] <= s_tdata[71:56];
            smp_reg[1] <= s_tdata[87:72];
            smp_reg[2] <= s_tdata[103:88];
            smp_reg[3] <= s_tdata[119:104];
        end
    end

    // Voice state.
    logic [ID_W-1:0]  sound_reg  [0:VOICES-1];
    logic [AW-1:0]    vaddr_reg  [0:VOICES-1];
    logic [LEN_W-1:0] played_reg [0:VOICES-1];
    logic [LEN_W-1:0] remain_reg [0:VOICES-1];

    // Selected voice of the current step.
    logic [VIW-1:0]             vi;
    logic [ID_W-1:0]            sound_sel;
    logic [LEN_W-1:0]           played_sel;
    logic                       active_sel;
    logic signed [SAMPLE_W-1:0] raw_sel;
    logic signed [ACC_W-1:0]    s_val;
    logic                       mix_step;

    assign vi         = cmd.idx[VIW-1:0];
    assign sound_sel  = sound_reg[vi];
    assign played_sel = played_reg[vi];
    assign active_sel = (remain_reg[vi] != '0);
    assign mix_step   = cmd.step && (func_reg == FUNC_MIX) && active_sel;

    always_comb
    begin
        raw_sel = smp_reg[cmd.idx[1:0]];
        if (cmd.idx >= IDX_W'(PORT_VOICES))
        begin
            s_val = '0;
        end
        else if (source_is_16bit_reg)
        begin
            s_val = ACC_W'(raw_sel);
        end
        else
        begin
            s_val = ACC_W'($signed({1'b0, raw_sel[7:0]}) - 9'sd128);
        end
    end

    // Accumulator and allocation search.
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                    free_found_reg, free_found_next;
    logic [VIW-1:0]          free_idx_reg, free_idx_next;
    logic                    same_found_reg, same_found_next;
    logic [VIW-1:0]          same_idx_reg, same_idx_next;
    logic [LEN_W-1:0]        same_most_reg, same_most_next;
    logic                    any_found_reg, any_found_next;
    logic [VIW-1:0]          any_idx_reg, any_idx_next;
    logic [LEN_W-1:0]        any_most_reg, any_most_next;

    always_comb
    begin
        acc_next        = acc_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        same_found_next = same_found_reg;
        same_idx_next   = same_idx_reg;
        same_most_next  = same_most_reg;
        any_found_next  = any_found_reg;
        any_idx_next    = any_idx_reg;
        any_most_next   = any_most_reg;
        if (cmd.load)
        begin
            acc_next        = '0;
            free_found_next = 1'b0;
            same_found_next = 1'b0;
            same_most_next  = '0;
            any_found_next  = 1'b0;
            any_most_next   = '0;
        end
        else if (cmd.step && (func_reg == FUNC_START))
        begin
            if (!free_found_reg && !active_sel)
            begin
                free_found_next = 1'b1;
                free_idx_next   = vi;
            end
            if ((sound_sel == id_reg) && (played_sel > same_most_reg))
            begin
                same_found_next = 1'b1;
                same_idx_next   = vi;
                same_most_next  = played_sel;
            end
            if (played_sel > any_most_reg)
            begin
                any_found_next = 1'b1;
                any_idx_next   = vi;
                any_most_next  = played_sel;
            end
        end
        else if (mix_step)
        begin
            acc_next = acc_reg + s_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_found_reg <= 1'b0;
            same_found_reg <= 1'b0;
            any_found_reg  <= 1'b0;
        end
        else
        begin
            free_found_reg <= free_found_next;
            same_found_reg <= same_found_next;
            any_found_reg  <= any_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        free_idx_reg  <= free_idx_next;
        same_idx_reg  <= same_idx_next;
        same_most_reg <= same_most_next;
        any_idx_reg   <= any_idx_next;
        any_most_reg  <= any_most_next;
    end

    // Allocation decision.
    logic             start_ok;
    logic [IDX_W-1:0] pick_idx;

    always_comb
    begin
        start_ok = (func_reg == FUNC_START) &&
                   (free_found_reg || same_found_reg || any_found_reg);
        if (free_found_reg)
        begin
            pick_idx = IDX_W'(free_idx_reg);
        end
        else if (same_found_reg)
        begin
            pick_idx = IDX_W'(same_idx_reg);
        end
        else
        begin
            pick_idx = IDX_W'(any_idx_reg);
        end
    end

    // Per-voice state update.
    for (genvar v = 0; v < VOICES; v++)
    begin : g_voice
        logic             sel;
        logic             commit;
        logic [ID_W-1:0]  sound_next;
        logic [AW-1:0]    vaddr_next;
        logic [LEN_W-1:0] played_next;
        logic [LEN_W-1:0] remain_next;

        assign sel    = (cmd.idx == IDX_W'(v));
        assign commit = cmd.finish && start_ok && (pick_idx == IDX_W'(v));

        always_comb
        begin
            sound_next  = sound_reg[v];
            vaddr_next  = vaddr_reg[v];
            played_next = played_reg[v];
            remain_next = remain_reg[v];
            if (commit)
            begin
                sound_next  = id_reg;
                vaddr_next  = base_reg;
                played_next = '0;
                remain_next = len_reg;
            end
            else if (mix_step && sel)
            begin
                vaddr_next  = vaddr_reg[v] + 1'b1;
                played_next = played_reg[v] + 1'b1;
                remain_next = remain_reg[v] - 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sound_reg[v]  <= '0;
                vaddr_reg[v]  <= '0;
                played_reg[v] <= '0;
                remain_reg[v] <= '0;
            end
            else
            begin
                sound_reg[v]  <= sound_next;
                vaddr_reg[v]  <= vaddr_next;
                played_reg[v] <= played_next;
                remain_reg[v] <= remain_next;
            end
        end
    end

    // Reported voices, with the voice being started taken into account.
    logic [PORT_VOICES-1:0]                 out_mask;
    logic [PORT_VOICES-1:0][OUT_ADDR_W-1:0] out_addr;

    for (genvar p = 0; p < PORT_VOICES; p++)
    begin : g_report
        if (p < VOICES)
        begin : g_live
            logic hit;
            assign hit         = start_ok && (pick_idx == IDX_W'(p));
            assign out_mask[p] = hit ? (len_reg != '0) : (remain_reg[p] != '0);
            assign out_addr[p] = OUT_ADDR_W'(hit ? base_reg : vaddr_reg[p]);
        end
        else
        begin : g_absent
            assign out_mask[p] = 1'b0;
            assign out_addr[p] = '0;
        end
    end

    // Clipping to the device format.
    logic signed [WIDE_W-1:0]   acc_wide;
    logic signed [WIDE_W-1:0]   scaled;
    logic signed [WIDE_W-1:0]   lo;
    logic signed [WIDE_W-1:0]   hi;
    logic signed [SAMPLE_W-1:0] mixed;

    always_comb
    begin
        acc_wide = WIDE_W'(acc_reg);
        if (!device_is_16bit_reg)
        begin
            scaled = acc_wide + WIDE_W'(BIAS_U8);
            lo     = '0;
            hi     = WIDE_W'(MAX_U8);
        end
        else
        begin
            scaled = source_is_16bit_reg ? acc_wide : (acc_wide <<< 8);
            lo     = WIDE_W'(MIN_S16);
            hi     = WIDE_W'(MAX_S16);
        end
        if (func_reg == FUNC_START)
        begin
            mixed = '0;
        end
        else if (scaled < lo)
        begin
            mixed = lo[SAMPLE_W-1:0];
        end
        else if (scaled > hi)
        begin
            mixed = hi[SAMPLE_W-1:0];
        end
        else
        begin
            mixed = scaled[SAMPLE_W-1:0];
        end
    end

    // Result register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]            chosen;

    assign chosen          = start_ok ? pick_idx[1:0] : 2'b00;
    assign status.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {1'b0, out_addr, out_mask, mixed, chosen, start_ok};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> verif/vam_mix_checker.sv
// Checker for the voice allocate-and-mix block: predicts each output transaction and compares it.
module vam_mix_checker
    import vam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic                  cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // sound_id, sound_base, sound_len, voice0_sample .. voice3_sample
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // accepted, chosen_voice, mixed_sample, active_mask, voice0_addr .. voice3_addr
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int NV = PORT_VOICES;

    typedef struct packed {
        logic                         accepted;
        logic [1:0]                   chosen;
        logic [SAMPLE_W-1:0]          mixed;
        logic [NV-1:0]                mask;
        logic [NV-1:0][OUT_ADDR_W-1:0] addr;
    } voice_report_t;

    logic              src_16;
    logic              dev_16;
    logic              voice_on    [NV];
    logic [ID_W-1:0]   voice_id    [NV];
    logic [LEN_W-1:0]  voice_start [NV];
    logic [LEN_W-1:0]  voice_count [NV];
    logic [LEN_W-1:0]  voice_left  [NV];

    voice_report_t awaited_reports [$];

    function automatic logic sounding(int v);
        return voice_on[v] && (voice_left[v] != '0);
    endfunction

    function automatic int clamp(int x, int lo, int hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic voice_report_t allocate_or_mix(logic func, logic [IN_DATA_W-1:0] d);
        voice_report_t    r;
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] most;
        int               pick;
        int               acc;
        int               s;
        int               level;
        r  = '0;
        id = d[7:0];
        if (func == FUNC_START) begin
            pick = -1;
            for (int v = 0; v < NV; v++)
                if (pick < 0 && !sounding(v))
                    pick = v;
            if (pick < 0) begin
                most = '0;
                for (int v = 0; v < NV; v++)
                    if (voice_id[v] == id && voice_count[v] > most)
                    begin
                        most = voice_count[v];
                        pick = v;
                    end
            end
            if (pick < 0) begin
                most = '0;
                for (int v = 0; v < NV; v++)
                    if (voice_count[v] > most)
                    begin
                        most = voice_count[v];
                        pick = v;
                    end
            end
            if (pick >= 0) begin
                voice_on[pick]    = 1'b1;
                voice_id[pick]    = id;
                voice_start[pick] = d[31:8];
                voice_count[pick] = '0;
                voice_left[pick]  = d[55:32];
                r.accepted        = 1'b1;
                r.chosen          = pick[1:0];
            end
        end
        else begin
            acc = 0;
            for (int v = 0; v < NV; v++)
                if (sounding(v))
                begin
                    if (src_16)
                        s = $signed(d[56 + 16*v +: 16]);
                    else
                    begin
                        s = d[56 + 16*v +: 8];
                        s = s - BIAS_U8;
                    end
                    acc = acc + s;
                    voice_count[v] = voice_count[v] + 1'b1;
                    voice_left[v]  = voice_left[v] - 1'b1;
                end
            if (!dev_16)
                level = clamp(acc + BIAS_U8, 0, MAX_U8);
            else if (!src_16)
                level = clamp(acc * 256, MIN_S16, MAX_S16);
            else
                level = clamp(acc, MIN_S16, MAX_S16);
            r.mixed = level[SAMPLE_W-1:0];
        end
        for (int v = 0; v < NV; v++) begin
            r.mask[v] = sounding(v);
            r.addr[v] = voice_start[v] + voice_count[v];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        voice_report_t seen;
        voice_report_t want;
        if (!rst_n) begin
            src_16 = 1'b0;
            dev_16 = 1'b0;
            for (int v = 0; v < NV; v++) begin
                voice_on[v]    = 1'b0;
                voice_id[v]    = '0;
                voice_start[v] = '0;
                voice_count[v] = '0;
                voice_left[v]  = '0;
            end
            awaited_reports.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_SOURCE_16)
                    src_16 = cfg_wdata;
                else
                    dev_16 = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                awaited_reports.push_back(allocate_or_mix(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready) begin
                seen.accepted = m_tdata[0];
                seen.chosen   = m_tdata[2:1];
                seen.mixed    = m_tdata[18:3];
                seen.mask     = m_tdata[22:19];
                for (int v = 0; v < NV; v++)
                    seen.addr[v] = m_tdata[23 + 24*v +: 24];
                if (awaited_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transaction: %h", m_tdata);
                end
                else begin
                    want = awaited_reports.pop_front();
                    if (want != seen) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"output mismatch: expected acc=%0d voice=%0d mix=%h ",
                                      "mask=%b addr=%h %h %h %h; got acc=%0d voice=%0d ",
                                      "mix=%h mask=%b addr=%h %h %h %h"},
                                     want.accepted, want.chosen, want.mixed, want.mask,
                                     want.addr[0], want.addr[1], want.addr[2], want.addr[3],
                                     seen.accepted, seen.chosen, seen.mixed, seen.mask,
                                     seen.addr[0], seen.addr[1], seen.addr[2], seen.addr[3]);
                    end
                end
            end
            outstanding = awaited_reports.size();
        end
    end

endmodule

>>> verif/voice_allocate_and_mix_core_test.sv
// Testbench top for the voice allocate-and-mix block: stimulus, flow control and verdict.
module voice_allocate_and_mix_core_test;

    import vam_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic                  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int send_idle;
    int recv_idle;
    int cycles;

    voice_allocate_and_mix_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    vam_mix_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("voice_allocate_and_mix_core_test failed");
            $finish;
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_in(logic [7:0] id, logic [23:0] base,
                                                     logic [23:0] len, logic [15:0] s0,
                                                     logic [15:0] s1, logic [15:0] s2,
                                                     logic [15:0] s3);
        return {s3, s2, s1, s0, len, base, id};
    endfunction

    task automatic send_item(logic func, logic [IN_DATA_W-1:0] data);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic start_sound(logic [7:0] id, logic [23:0] base, logic [23:0] len);
        send_item(FUNC_START, pack_in(id, base, len, 16'h0, 16'h0, 16'h0, 16'h0));
    endtask

    task automatic mix_once(logic [15:0] s0, logic [15:0] s1, logic [15:0] s2,
                            logic [15:0] s3);
        send_item(FUNC_MIX, pack_in(8'h0, 24'h0, 24'h0, s0, s1, s2, s3));
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_mode(logic src16, logic dev16);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SOURCE_16;
        cfg_wdata <= src16;
        @(negedge clk);
        cfg_index <= CFG_DEVICE_16;
        cfg_wdata <= dev16;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_item(logic force_start);
        logic [7:0]  id;
        logic [23:0] base;
        logic [23:0] len;
        logic [63:0] smp;
        int          pick;
        id   = ($urandom_range(99) < 75) ? 8'($urandom_range(3)) : 8'($urandom);
        base = 24'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            len = 24'($urandom_range(24));
        else if (pick < 92)
            len = 24'($urandom_range(400));
        else if (pick < 96)
            len = 24'hFFFFFF;
        else
            len = 24'($urandom);
        if (force_start && len == '0)
            len = 24'd7;
        pick = $urandom_range(99);
        if (pick < 8)
            smp = {4{16'h7FFF}};
        else if (pick < 16)
            smp = {4{16'h8000}};
        else if (pick < 21)
            smp = {4{16'h00FF}};
        else if (pick < 26)
            smp = {4{16'hFF00}};
        else
            smp = {$urandom, $urandom};
        if (force_start || $urandom_range(99) < 38)
            send_item(FUNC_START, {smp, len, base, id});
        else
            send_item(FUNC_MIX, {smp, len, base, id});
    endtask

    initial begin
        int sent;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SOURCE_16;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_START;
        send_idle = 0;
        recv_idle = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_mode(1'b0, 1'b0);
        mix_once(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        start_sound(8'd5, 24'hFFFFFE, 24'd4);
        start_sound(8'd5, 24'h000000, 24'd0);
        start_sound(8'd7, 24'h000100, 24'hFFFFFF);
        start_sound(8'd9, 24'h123456, 24'd3);
        start_sound(8'hFF, 24'hFFFFFF, 24'd9);
        start_sound(8'd5, 24'h000000, 24'd6);
        mix_once(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        mix_once(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        start_sound(8'd5, 24'h00000A, 24'd2);
        start_sound(8'h42, 24'h000020, 24'd5);
        mix_once(16'h8080, 16'h7F7F, 16'h0001, 16'hFF80);
        start_sound(8'h42, 24'h000040, 24'd5);
        mix_once(16'h1234, 16'h0080, 16'h00FE, 16'h8000);
        settle();
        set_mode(1'b1, 1'b1);
        mix_once(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        mix_once(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        mix_once(16'h1234, 16'hFFFB, 16'h0000, 16'h0007);
        settle();
        set_mode(1'b0, 1'b1);
        mix_once(16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF);
        mix_once(16'h0081, 16'h0080, 16'h007F, 16'hFF80);
        settle();
        set_mode(1'b1, 1'b0);
        mix_once(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        mix_once(16'h8000, 16'h0000, 16'h0000, 16'h0000);

        for (int blk = 0; blk < 6; blk++) begin
            settle();
            set_mode(blk[0], blk[1]);
            send_idle = (blk < 2) ? 31 : ((blk < 4) ? 81 : 0);
            recv_idle = (blk < 2) ? 81 : ((blk < 4) ? 31 : 0);
            sent = 0;
            while (sent < 300) begin
                if ($urandom_range(39) == 0) begin
                    repeat (5) random_item(1'b1);
                    sent += 5;
                end
                else begin
                    random_item(1'b0);
                    sent++;
                end
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("voice_allocate_and_mix_core_test passed");
        else
            $display("voice_allocate_and_mix_core_test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/vam_pkg.sv
rtl/vam_ctrl.sv
rtl/vam_datapath.sv
rtl/voice_allocate_and_mix_core.sv
verif/vam_mix_checker.sv
verif/voice_allocate_and_mix_core_test.sv
